// ===== design/bm25_pkg.sv =====
// shared types, constants and the log2 table of the bm25 scorer
`default_nettype none
package bm25_pkg;

  localparam int SCORE_FRAC_BITS = 16;
  localparam int LOG_TABLE_BITS  = 6;

  localparam int ROM_SIZE   = 1 << LOG_TABLE_BITS;
  localparam int LOG_IN_W   = 26;
  localparam int LOG_FRAC_W = LOG_IN_W - 1;
  localparam int LOG_R_W    = LOG_FRAC_W - LOG_TABLE_BITS;
  localparam int LOG_E_W    = 5;
  localparam int ROM_W      = 25;
  localparam int LOG_W      = 30;
  localparam int LN2_Q24    = 11629080;

  localparam int IDF_W      = 30;
  localparam int RATIO_W    = 36;
  localparam int INNER_W    = 37;
  localparam int DEN_W      = 54;
  localparam int NUM_W      = 33;
  localparam int NORM_W     = 21;
  localparam int TP_W       = IDF_W + NORM_W;
  localparam int TERM_SHIFT = 40 - SCORE_FRAC_BITS;
  localparam int DIV_W      = 61;
  localparam int DIV_CNT_W  = 6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CFG_TOTAL_DOCS    = 2'd0;
  localparam logic [1:0] CFG_AVG_LENGTH    = 2'd1;
  localparam logic [1:0] CFG_K1_GAIN       = 2'd2;
  localparam logic [1:0] CFG_LENGTH_WEIGHT = 2'd3;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_FAULT,
    KIND_SCORE
  } bm25_kind_e;

  typedef struct packed {
    logic [23:0] total_docs;
    logic [23:0] avg_doc_length;
    logic [15:0] k1_gain;
    logic [12:0] length_weight;
  } bm25_cfg_t;

  typedef struct packed {
    logic [31:0] doc_id;
    logic [15:0] term_freq;
    logic [23:0] doc_freq;
    logic [15:0] doc_length;
    logic        last_term;
    bm25_kind_e  kind;
  } bm25_item_t;

  typedef logic [ROM_W-1:0] log_rom_t [0:ROM_SIZE];

  // log2(1 + i/ROM_SIZE) in q1.24 by repeated squaring
  function automatic log_rom_t build_log_rom();
    log_rom_t          rom;
    logic [63:0]       m;
    logic [ROM_W-1:0]  acc;
    for (int i = 0; i <= ROM_SIZE; i++) begin
      if (i == ROM_SIZE) begin
        rom[i] = ROM_W'(1) << 24;
      end else begin
        m   = 64'(ROM_SIZE + i) << (30 - LOG_TABLE_BITS);
        acc = '0;
        for (int k = 0; k < 24; k++) begin
          m   = (m * m) >> 30;
          acc = {acc[ROM_W-2:0], 1'b0};
          if (m >= 64'h8000_0000) begin
            m      = m >> 1;
            acc[0] = 1'b1;
          end
        end
        rom[i] = acc;
      end
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage
`default_nettype wire

// ===== design/bm25_fifo.sv =====
// short queue of classified terms between front and back
`default_nettype none
module bm25_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  bm25_pkg::bm25_item_t   item_i,
  output logic                   full_o,
  input  wire                    pop_i,
  output logic                   valid_o,
  output bm25_pkg::bm25_item_t   item_o
);

  bm25_pkg::bm25_item_t mem_q [bm25_pkg::QUEUE_DEPTH];
  logic [bm25_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [bm25_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (bm25_pkg::QPTR_W+1)'(bm25_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == bm25_pkg::QPTR_W'(bm25_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == bm25_pkg::QPTR_W'(bm25_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/bm25_front.sv =====
// input side: takes terms, clamps doc_freq and sorts them into kinds
`default_nettype none
module bm25_front (
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire [31:0]             doc_id_i,
  input  wire [15:0]             term_freq_i,
  input  wire [23:0]             doc_freq_i,
  input  wire [15:0]             doc_length_i,
  input  wire                    last_term_i,
  input  bm25_pkg::bm25_cfg_t    cfg_i,
  input  wire                    full_i,
  output logic                   push_o,
  output bm25_pkg::bm25_item_t   item_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.doc_id     = doc_id_i;
    item_o.term_freq  = term_freq_i;
    item_o.doc_freq   = (doc_freq_i > cfg_i.total_docs) ? cfg_i.total_docs : doc_freq_i;
    item_o.doc_length = doc_length_i;
    item_o.last_term  = last_term_i;
    if (term_freq_i == '0) begin
      item_o.kind = bm25_pkg::KIND_SKIP;
    end else if (cfg_i.avg_doc_length == '0) begin
      item_o.kind = bm25_pkg::KIND_FAULT;
    end else begin
      item_o.kind = bm25_pkg::KIND_SCORE;
    end
  end

endmodule
`default_nettype wire

// ===== design/bm25_log2.sv =====
// three stage log2 unit, table with linear interpolation, q.24 result
`default_nettype none
module bm25_log2 (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire [bm25_pkg::LOG_IN_W-1:0]     x_i,
  output logic                             done_o,
  output logic [bm25_pkg::LOG_W-1:0]       y_o
);

  localparam int LTB = bm25_pkg::LOG_TABLE_BITS;

  logic [2:0]                         v_q;
  logic [bm25_pkg::LOG_E_W-1:0]       e_c, e1_q, e2_q;
  logic [bm25_pkg::LOG_FRAC_W-1:0]    frac_c;
  logic [LTB-1:0]                     idx1_q;
  logic [bm25_pkg::LOG_R_W-1:0]       r1_q, r2_q;
  logic [bm25_pkg::ROM_W-1:0]         t0_c, t1_c, t0_q, diff_q;
  logic [LTB:0]                       idx_next;
  logic [bm25_pkg::ROM_W+bm25_pkg::LOG_R_W-1:0] interp_c;
  logic [bm25_pkg::LOG_W-1:0]         y_q;

  always_comb begin
    e_c = '0;
    for (int i = 0; i < bm25_pkg::LOG_IN_W; i++) begin
      if (x_i[i]) begin
        e_c = bm25_pkg::LOG_E_W'(i);
      end
    end
    frac_c = bm25_pkg::LOG_FRAC_W'(x_i << (bm25_pkg::LOG_E_W'(bm25_pkg::LOG_FRAC_W) - e_c));
  end

  assign idx_next = {1'b0, idx1_q} + 1'b1;
  assign t0_c     = bm25_pkg::LOG_ROM[idx1_q];
  assign t1_c     = bm25_pkg::LOG_ROM[idx_next];
  assign interp_c = (bm25_pkg::ROM_W + bm25_pkg::LOG_R_W)'(diff_q) *
                    (bm25_pkg::ROM_W + bm25_pkg::LOG_R_W)'(r2_q);

  always_ff @(posedge clk_i) begin
    e1_q   <= e_c;
    idx1_q <= frac_c[bm25_pkg::LOG_FRAC_W-1 -: LTB];
    r1_q   <= frac_c[bm25_pkg::LOG_R_W-1:0];
    e2_q   <= e1_q;
    r2_q   <= r1_q;
    t0_q   <= t0_c;
    diff_q <= t1_c - t0_c;
    y_q    <= {e2_q, 24'b0} + bm25_pkg::LOG_W'(t0_q) +
              bm25_pkg::LOG_W'(interp_c >> bm25_pkg::LOG_R_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], start_i};
    end
  end

  assign done_o = v_q[2];
  assign y_o    = y_q;

endmodule
`default_nettype wire

// ===== design/bm25_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module bm25_div (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  input  wire [bm25_pkg::DEN_W-1:0]          rem_init_i,
  input  wire [bm25_pkg::DIV_W-1:0]          word_init_i,
  input  wire [bm25_pkg::DIV_CNT_W-1:0]      count_i,
  input  wire [bm25_pkg::DEN_W-1:0]          divisor_i,
  output logic                               done_o,
  output logic [bm25_pkg::DIV_W-1:0]         word_o
);

  logic [bm25_pkg::DEN_W-1:0]     rem_q, div_q;
  logic [bm25_pkg::DIV_W-1:0]     word_q;
  logic [bm25_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;
  logic [bm25_pkg::DEN_W:0]       trial, diff;
  logic                           ge;

  assign trial = {rem_q, word_q[bm25_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_init_i;
      word_q <= word_init_i;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[bm25_pkg::DEN_W-1:0] : trial[bm25_pkg::DEN_W-1:0];
      word_q <= {word_q[bm25_pkg::DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= count_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == bm25_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign word_o = word_q;

endmodule
`default_nettype wire

// ===== design/bm25_back.sv =====
// scoring sequencer: idf, length norm, term score, per-document sum
`default_nettype none
module bm25_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  bm25_pkg::bm25_cfg_t    cfg_i,
  input  wire                    q_valid_i,
  input  bm25_pkg::bm25_item_t   q_item_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [31:0]            score_doc_id_o,
  output logic [31:0]            doc_score_o,
  output logic                   bad_average_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_LOGB   = 4'd2;
  localparam logic [3:0] ST_LOGW   = 4'd3;
  localparam logic [3:0] ST_IDF    = 4'd4;
  localparam logic [3:0] ST_RATIOW = 4'd5;
  localparam logic [3:0] ST_BRAT   = 4'd6;
  localparam logic [3:0] ST_INNER  = 4'd7;
  localparam logic [3:0] ST_KDEN   = 4'd8;
  localparam logic [3:0] ST_NUM    = 4'd9;
  localparam logic [3:0] ST_DIVN   = 4'd10;
  localparam logic [3:0] ST_DIVW   = 4'd11;
  localparam logic [3:0] ST_TERM   = 4'd12;
  localparam logic [3:0] ST_ACC    = 4'd13;
  localparam logic [3:0] ST_DONE   = 4'd14;

  localparam int BP_W = 13 + bm25_pkg::RATIO_W;

  logic [3:0]                        state_q, state_d;
  bm25_pkg::bm25_item_t              item_q;
  logic [31:0]                       sum_q, sum_d;
  logic                              fault_q, fault_d;
  logic                              got_a_q, got_a_d;
  logic [bm25_pkg::LOG_W-1:0]        la_q, ld_q;
  logic [bm25_pkg::IDF_W-1:0]        idf_q;
  logic [bm25_pkg::RATIO_W-1:0]      ratio_q;
  logic [BP_W-1:0]                   bprod_q;
  logic [bm25_pkg::INNER_W-1:0]      inner_q;
  logic [bm25_pkg::DEN_W-1:0]        den_q;
  logic [bm25_pkg::NUM_W-1:0]        num_q;
  logic [bm25_pkg::NORM_W-1:0]       norm_q;
  logic [bm25_pkg::TP_W-1:0]         tprod_q, term_c;
  logic [32:0]                       acc_c;
  logic [31:0]                       term32_c;
  logic [12:0]                       b_c;
  logic [BP_W:0]                     inner_sum_c;
  logic [53:0]                       idf_prod_c;
  logic                              out_valid_q;
  logic [31:0]                       out_id_q, out_score_q;
  logic                              out_bad_q;

  logic                              log_start, log_done;
  logic [bm25_pkg::LOG_IN_W-1:0]     log_x;
  logic [bm25_pkg::LOG_W-1:0]        log_y;
  logic                              div_start, div_done;
  logic [bm25_pkg::DEN_W-1:0]        div_rem, div_den;
  logic [bm25_pkg::DIV_W-1:0]        div_word, div_q;
  logic [bm25_pkg::DIV_CNT_W-1:0]    div_cnt;

  bm25_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .y_o     (log_y)
  );

  bm25_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .rem_init_i  (div_rem),
    .word_init_i (div_word),
    .count_i     (div_cnt),
    .divisor_i   (div_den),
    .done_o      (div_done),
    .word_o      (div_q)
  );

  assign b_c         = (cfg_i.length_weight > 13'd4096) ? 13'd4096 : cfg_i.length_weight;
  assign inner_sum_c = (BP_W+1)'({13'd4096 - b_c, 12'b0}) + (BP_W+1)'(bprod_q);
  assign idf_prod_c  = 54'(ld_q) * 54'(bm25_pkg::LN2_Q24);
  assign term_c      = tprod_q >> bm25_pkg::TERM_SHIFT;
  assign term32_c    = (|term_c[bm25_pkg::TP_W-1:32]) ? 32'hFFFF_FFFF : term_c[31:0];
  assign acc_c       = {1'b0, sum_q} + {1'b0, term32_c};

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    fault_d   = fault_q;
    got_a_d   = got_a_q;
    q_pop_o   = 1'b0;
    log_start = 1'b0;
    log_x     = bm25_pkg::LOG_IN_W'({cfg_i.total_docs, 1'b0}) + bm25_pkg::LOG_IN_W'(2);
    div_start = 1'b0;
    div_rem   = '0;
    div_word  = {item_q.doc_length, 20'b0, 25'b0};
    div_cnt   = bm25_pkg::DIV_CNT_W'(bm25_pkg::RATIO_W);
    div_den   = bm25_pkg::DEN_W'(cfg_i.avg_doc_length);
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.kind == bm25_pkg::KIND_SCORE) begin
            state_d = ST_START;
          end else begin
            if (q_item_i.kind == bm25_pkg::KIND_FAULT) begin
              fault_d = 1'b1;
            end
            state_d = ST_DONE;
          end
        end
      end
      ST_START: begin
        log_start = 1'b1;
        div_start = 1'b1;
        state_d   = ST_LOGB;
      end
      ST_LOGB: begin
        log_start = 1'b1;
        log_x     = bm25_pkg::LOG_IN_W'({item_q.doc_freq, 1'b1});
        state_d   = ST_LOGW;
      end
      ST_LOGW: begin
        if (log_done) begin
          if (got_a_q) begin
            got_a_d = 1'b0;
            state_d = ST_IDF;
          end else begin
            got_a_d = 1'b1;
          end
        end
      end
      ST_IDF:    state_d = ST_RATIOW;
      ST_RATIOW: if (div_done) state_d = ST_BRAT;
      ST_BRAT:   state_d = ST_INNER;
      ST_INNER:  state_d = ST_KDEN;
      ST_KDEN:   state_d = ST_NUM;
      ST_NUM:    state_d = ST_DIVN;
      ST_DIVN: begin
        div_start = 1'b1;
        div_rem   = bm25_pkg::DEN_W'({num_q, 7'b0});
        div_word  = '0;
        div_cnt   = bm25_pkg::DIV_CNT_W'(bm25_pkg::NORM_W);
        div_den   = den_q;
        state_d   = ST_DIVW;
      end
      ST_DIVW:   if (div_done) state_d = ST_TERM;
      ST_TERM:   state_d = ST_ACC;
      ST_ACC: begin
        sum_d   = acc_c[32] ? 32'hFFFF_FFFF : acc_c[31:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!item_q.last_term) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          sum_d   = '0;
          fault_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (state_q == ST_LOGW && log_done && !got_a_q) begin
      la_q <= log_y;
    end
    if (state_q == ST_LOGW && log_done && got_a_q) begin
      ld_q <= la_q - log_y;
    end
    if (state_q == ST_IDF) begin
      idf_q <= bm25_pkg::IDF_W'(idf_prod_c >> 24);
    end
    if (state_q == ST_RATIOW && div_done) begin
      ratio_q <= div_q[bm25_pkg::RATIO_W-1:0];
    end
    if (state_q == ST_BRAT) begin
      bprod_q <= BP_W'(b_c) * BP_W'(ratio_q);
    end
    if (state_q == ST_INNER) begin
      inner_q <= bm25_pkg::INNER_W'(inner_sum_c >> 12);
    end
    if (state_q == ST_KDEN) begin
      den_q <= bm25_pkg::DEN_W'({item_q.term_freq, 24'b0}) +
               bm25_pkg::DEN_W'(cfg_i.k1_gain) * bm25_pkg::DEN_W'(inner_q);
    end
    if (state_q == ST_NUM) begin
      num_q <= bm25_pkg::NUM_W'(item_q.term_freq) *
               bm25_pkg::NUM_W'({1'b0, cfg_i.k1_gain} + 17'd4096);
    end
    if (state_q == ST_DIVW && div_done) begin
      norm_q <= div_q[bm25_pkg::NORM_W-1:0];
    end
    if (state_q == ST_TERM) begin
      tprod_q <= bm25_pkg::TP_W'(idf_q) * bm25_pkg::TP_W'(norm_q);
    end
    if (state_q == ST_DONE && item_q.last_term && (!out_valid_q || out_ready_i)) begin
      out_id_q    <= item_q.doc_id;
      out_score_q <= sum_q;
      out_bad_q   <= fault_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      fault_q     <= 1'b0;
      got_a_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      fault_q <= fault_d;
      got_a_q <= got_a_d;
      if (state_q == ST_DONE && item_q.last_term && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign score_doc_id_o = out_id_q;
  assign doc_score_o    = out_score_q;
  assign bad_average_o  = out_bad_q;

endmodule
`default_nettype wire

// ===== design/bm25_document_scorer.sv =====
// top level of the okapi bm25 document scorer
// Takes one query term of one document per input beat and adds its fixed-point
// BM25 score (idf from a log2 table times the saturating length-normalized
// frequency) to a running per-document sum; the beat marked last_term emits the
// sum in unsigned Q16.16 with the document id and a flag for a zero average
// length, then clears the sum. A scored term waits on the single radix-2 divider,
// which works out len/avg (36 steps) and then the frequency norm (21 steps) one
// bit a cycle; a term with zero frequency or a zero average goes straight from
// idle to done. A two-entry queue holds terms that arrive while the scorer is busy,
// and the result register lets the next term start while a result waits. The user
// writes configuration through cfg_we_i/cfg_idx_i (0 total docs, 1 average length,
// 2 k1, 3 b) only while the block is idle; the block does not enforce this.
`default_nettype none
module bm25_document_scorer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire [1:0]   cfg_idx_i,
  input  wire [23:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire [31:0]  doc_id_i,
  input  wire [15:0]  term_freq_i,
  input  wire [23:0]  doc_freq_i,
  input  wire [15:0]  doc_length_i,
  input  wire         last_term_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] score_doc_id_o,
  output logic [31:0] doc_score_o,
  output logic        bad_average_o
);

  bm25_pkg::bm25_cfg_t  cfg_q;
  bm25_pkg::bm25_item_t push_item, head_item;
  logic                 push, full, head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_docs     <= 24'd0;
      cfg_q.avg_doc_length <= 24'd256;
      cfg_q.k1_gain        <= 16'd6144;
      cfg_q.length_weight  <= 13'd3072;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bm25_pkg::CFG_TOTAL_DOCS:    cfg_q.total_docs     <= cfg_data_i;
        bm25_pkg::CFG_AVG_LENGTH:    cfg_q.avg_doc_length <= cfg_data_i;
        bm25_pkg::CFG_K1_GAIN:       cfg_q.k1_gain        <= cfg_data_i[15:0];
        bm25_pkg::CFG_LENGTH_WEIGHT: cfg_q.length_weight  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  bm25_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .doc_id_i     (doc_id_i),
    .term_freq_i  (term_freq_i),
    .doc_freq_i   (doc_freq_i),
    .doc_length_i (doc_length_i),
    .last_term_i  (last_term_i),
    .cfg_i        (cfg_q),
    .full_i       (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  bm25_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  bm25_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (head_valid),
    .q_item_i       (head_item),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .score_doc_id_o (score_doc_id_o),
    .doc_score_o    (doc_score_o),
    .bad_average_o  (bad_average_o)
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench of the bm25 document scorer with random config phases
`default_nettype none
module testbench;

  typedef struct {
    logic [31:0] doc_id;
    logic [15:0] term_freq;
    logic [23:0] doc_freq;
    logic [15:0] doc_length;
    logic        last_term;
  } term_t;

  typedef struct {
    logic [31:0] doc_id;
    logic [31:0] score;
    logic        bad_avg;
  } score_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] doc_id_i;
  logic [15:0] term_freq_i;
  logic [23:0] doc_freq_i;
  logic [15:0] doc_length_i;
  logic        last_term_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] score_doc_id_o;
  logic [31:0] doc_score_o;
  logic        bad_average_o;

  bm25_document_scorer u_dut (.*);

  term_t       term_q[$];
  score_t      score_q[$];
  logic [31:0] log2_tab [0:bm25_pkg::ROM_SIZE];
  logic [23:0] n_docs, avg_len;
  logic [15:0] k1;
  logic [12:0] b_wt;
  logic [31:0] run_sum;
  logic        run_fault;
  int          n_fail;
  int          stall_cnt;
  bit          in_taken;
  bit          no_idle;
  bit          hold_done;
  int          gap_cnt;
  int          hold_cnt;
  int          out_beats;
  int          quiet_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int          e;
    logic [63:0] f, idx, rem, t0, t1;
    e = 0;
    while (e < 30 && (x >> (e + 1)) != 0) e++;
    f   = (x << (40 - e)) - (64'd1 << 40);
    idx = (f >> (40 - bm25_pkg::LOG_TABLE_BITS)) & (bm25_pkg::ROM_SIZE - 1);
    rem = f & ((64'd1 << (40 - bm25_pkg::LOG_TABLE_BITS)) - 1);
    t0  = log2_tab[idx];
    t1  = log2_tab[idx + 1];
    return (64'(e) << 24) + t0 + (((t1 - t0) * rem) >> (40 - bm25_pkg::LOG_TABLE_BITS));
  endfunction

  // adds one term to the running document score, returns 1 when a score is due
  function automatic bit score_term(term_t t, output score_t s);
    logic [63:0] n, df, bw, ld, idf, ratio, inner, den, norm, term, sum;
    if (t.term_freq != 0) begin
      if (avg_len == 0) begin
        run_fault = 1'b1;
      end else begin
        n   = n_docs;
        df  = (t.doc_freq > n_docs) ? n : 64'(t.doc_freq);
        bw  = (b_wt > 13'd4096) ? 64'd4096 : 64'(b_wt);
        ld  = log2_fix(2 * n + 2) - log2_fix(2 * df + 1);
        idf = (ld * bm25_pkg::LN2_Q24) >> 24;
        ratio = (64'(t.doc_length) << 20) / avg_len;
        inner = ((4096 - bw) * 4096 + bw * ratio) >> 12;
        den   = (64'(t.term_freq) << 24) + 64'(k1) * inner;
        norm  = ((64'(t.term_freq) * (64'(k1) + 4096)) << 28) / den;
        term  = (idf * norm) >> bm25_pkg::TERM_SHIFT;
        if (term > 64'hFFFF_FFFF) term = 64'hFFFF_FFFF;
        sum = 64'(run_sum) + term;
        run_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end
    end
    s.doc_id  = t.doc_id;
    s.score   = run_sum;
    s.bad_avg = run_fault;
    if (t.last_term) begin
      run_sum   = '0;
      run_fault = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic write_cfg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      bm25_pkg::CFG_TOTAL_DOCS:    n_docs  = val;
      bm25_pkg::CFG_AVG_LENGTH:    avg_len = val;
      bm25_pkg::CFG_K1_GAIN:       k1      = val[15:0];
      bm25_pkg::CFG_LENGTH_WEIGHT: b_wt    = val[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_cfg(logic [23:0] n, logic [23:0] a, logic [15:0] k, logic [12:0] bw);
    write_cfg(bm25_pkg::CFG_TOTAL_DOCS, n);
    write_cfg(bm25_pkg::CFG_AVG_LENGTH, a);
    write_cfg(bm25_pkg::CFG_K1_GAIN, 24'(k));
    write_cfg(bm25_pkg::CFG_LENGTH_WEIGHT, 24'(bw));
  endtask

  task automatic add_term(logic [31:0] id, logic [15:0] tf, logic [23:0] df,
                          logic [15:0] len, logic last);
    term_t t;
    t.doc_id = id; t.term_freq = tf; t.doc_freq = df;
    t.doc_length = len; t.last_term = last;
    term_q.push_back(t);
  endtask

  task automatic add_random_docs(int n_terms);
    int          left, k, r;
    logic [31:0] id;
    logic [15:0] tf, len;
    logic [23:0] df;
    left = n_terms;
    while (left > 0) begin
      k  = $urandom_range(6, 1);
      id = $urandom;
      len = ($urandom_range(99) < 15) ? 16'($urandom) : 16'($urandom_range(2000, 50));
      for (int i = 0; i < k; i++) begin
        r  = $urandom_range(99);
        tf = (r < 10) ? 16'd0 : (r < 20) ? 16'($urandom) : 16'($urandom_range(20, 1));
        df = ($urandom_range(99) < 25) ? 24'($urandom) :
             24'($urandom_range(32'(n_docs) + 3, 0));
        if ($urandom_range(99) < 3) len = 16'($urandom);
        add_term(id, tf, df, len, i == k - 1);
      end
      left -= k;
    end
  endtask

  task automatic drain();
    while (term_q.size() != 0 || in_valid_i || score_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // sender
  always @(negedge clk_i) begin
    term_t t;
    if (in_valid_i && !in_taken) begin
    end else if (gap_cnt > 0 && !no_idle) begin
      in_valid_i <= 1'b0;
      gap_cnt    <= gap_cnt - 1;
    end else if (term_q.size() != 0) begin
      t = term_q.pop_front();
      in_valid_i   <= 1'b1;
      doc_id_i     <= t.doc_id;
      term_freq_i  <= t.term_freq;
      doc_freq_i   <= t.doc_freq;
      doc_length_i <= t.doc_length;
      last_term_i  <= t.last_term;
      gap_cnt      <= pick_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver, with one long hold-off once results are flowing
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= hold_cnt - 1;
    end else if (!hold_done && out_beats >= 40) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= 400;
      hold_done   <= 1'b1;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= (pick_gap() == 0);
    end
  end

  // accepted beats on both sides, prediction and check
  always @(posedge clk_i) begin
    term_t  t;
    score_t s, want;
    in_taken = in_valid_i && in_ready_o;
    if (in_taken) begin
      t.doc_id = doc_id_i; t.term_freq = term_freq_i; t.doc_freq = doc_freq_i;
      t.doc_length = doc_length_i; t.last_term = last_term_i;
      if (score_term(t, s)) score_q.push_back(s);
    end
    if (out_valid_o && out_ready_i) begin
      out_beats++;
      if (score_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected score beat doc %h score %h", score_doc_id_o,
                                   doc_score_o);
      end else begin
        want = score_q.pop_front();
        if (want.doc_id !== score_doc_id_o || want.score !== doc_score_o ||
            want.bad_avg !== bad_average_o) begin
          n_fail++;
          if (n_fail <= 10)
            $display("score beat: exp doc %h score %h bad %b, got doc %h score %h bad %b",
                     want.doc_id, want.score, want.bad_avg,
                     score_doc_id_o, doc_score_o, bad_average_o);
        end
      end
    end
    if (in_taken || (out_valid_o && out_ready_i)) quiet_cnt = 0;
    else quiet_cnt++;
    if (quiet_cnt >= 20000) begin
      $display("bm25_document_scorer: mismatch");
      $finish;
    end
  end

  initial begin
    logic [63:0] m;
    logic [31:0] acc;
    for (int i = 0; i <= bm25_pkg::ROM_SIZE; i++) begin
      if (i == bm25_pkg::ROM_SIZE) begin
        log2_tab[i] = 32'd1 << 24;
      end else begin
        m   = 64'(bm25_pkg::ROM_SIZE + i) << (30 - bm25_pkg::LOG_TABLE_BITS);
        acc = '0;
        for (int k = 0; k < 24; k++) begin
          m   = (m * m) >> 30;
          acc = acc << 1;
          if (m >= 64'h8000_0000) begin
            m      = m >> 1;
            acc[0] = 1'b1;
          end
        end
        log2_tab[i] = acc;
      end
    end
    n_docs = 0; avg_len = 256; k1 = 6144; b_wt = 3072;
    run_sum = 0; run_fault = 0; n_fail = 0;
    in_taken = 0; no_idle = 0; hold_done = 0; gap_cnt = 0; hold_cnt = 0;
    out_beats = 0; quiet_cnt = 0;
    cfg_we_i = 0; cfg_idx_i = bm25_pkg::CFG_TOTAL_DOCS; cfg_data_i = '0;
    in_valid_i = 0; doc_id_i = '0; term_freq_i = '0; doc_freq_i = '0;
    doc_length_i = '0; last_term_i = 0; out_ready_i = 0;
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed terms under the reset config, then with a real document total, extreme values and a zero average length
    add_term(32'h0, 16'd5, 24'd0, 16'd100, 1'b1);
    drain();
    set_cfg(24'd1000, 24'd256 * 300, 16'd6144, 13'd3072);
    add_term(32'hFFFF_FFFF, 16'd0, 24'd10, 16'd300, 1'b1);
    add_term(32'h1234_5678, 16'hFFFF, 24'd0, 16'd0, 1'b0);
    add_term(32'h1234_5678, 16'd1, 24'hFF_FFFF, 16'hFFFF, 1'b0);
    add_term(32'h1234_5678, 16'd0, 24'd999, 16'd300, 1'b0);
    add_term(32'h1234_5678, 16'd3, 24'd1000, 16'd300, 1'b1);
    add_term(32'hA5A5_5A5A, 16'd2, 24'd1001, 16'd1, 1'b1);
    add_term(32'h5A5A_A5A5, 16'd7, 24'd500, 16'd300, 1'b0);
    add_term(32'h5A5A_A5A5, 16'hFFFF, 24'd1, 16'hFFFF, 1'b1);
    drain();
    set_cfg(24'hFF_FFFF, 24'd1, 16'hFFFF, 13'd4096);
    add_term(32'h0000_0001, 16'hFFFF, 24'd0, 16'hFFFF, 1'b0);
    add_term(32'h0000_0001, 16'hFFFF, 24'd0, 16'hFFFF, 1'b0);
    add_term(32'h0000_0001, 16'hFFFF, 24'd0, 16'hFFFF, 1'b0);
    add_term(32'h0000_0001, 16'd1, 24'hFF_FFFF, 16'd0, 1'b1);
    drain();
    set_cfg(24'd50, 24'd0, 16'd6144, 13'd3072);
    add_term(32'h0BAD_0A0E, 16'd4, 24'd3, 16'd10, 1'b1);
    add_term(32'h0BAD_0A0F, 16'd0, 24'd3, 16'd10, 1'b1);
    drain();

    // random phases over several configs, extremes among them
    add_random_docs(60);
    drain();
    set_cfg(24'hFF_FFFF, 24'hFF_FFFF, 16'd0, 13'd0);
    add_random_docs(50);
    drain();
    set_cfg(24'd200, 24'd256 * 500, 16'd4096, 13'h1FFF);
    no_idle = 1;
    add_random_docs(40);
    drain();
    no_idle = 0;
    for (int p = 0; p < 6; p++) begin
      set_cfg(($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(5000)),
              ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(24'hFF_FFFF, 1)),
              16'($urandom), 13'($urandom));
      add_random_docs(50);
      drain();
    end

    if (n_fail == 0) $display("bm25_document_scorer: match");
    else $display("bm25_document_scorer: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
